// ===== rtl/core/rgsr_pkg.sv =====
// Shared types and constants for the ring grid submap region split block.
package rgsr_pkg;

    // Largest supported buffer dimension
    localparam int MAX_DIM     = 1024;
    localparam int NUM_REGIONS = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BUF_ROWS   = 2'd0;
    localparam logic [1:0] CFG_BUF_COLS   = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_ROW = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_COL = 2'd3;

    // Register reset values
    localparam logic [10:0] RST_BUF_ROWS   = 11'd1024;
    localparam logic [10:0] RST_BUF_COLS   = 11'd1024;
    localparam logic [9:0]  RST_ORIGIN_ROW = 10'd0;
    localparam logic [9:0]  RST_ORIGIN_COL = 10'd0;

    // Request transaction
    typedef struct packed {
        logic [9:0]  corner_row;
        logic [9:0]  corner_col;
        logic [10:0] span_rows;
        logic [10:0] span_cols;
    } t_req;

    // Result transaction
    typedef struct packed {
        logic [1:0]  region_id;
        logic [9:0]  piece_row;
        logic [9:0]  piece_col;
        logic [10:0] piece_rows;
        logic [10:0] piece_cols;
        logic        success;
        logic        final_piece;
    } t_res;

    // Current configuration
    typedef struct packed {
        logic [10:0] buf_rows;
        logic [10:0] buf_cols;
        logic [9:0]  origin_row;
        logic [9:0]  origin_col;
    } t_cfg;

    // One region's piece
    typedef struct packed {
        logic [9:0]  row;
        logic [9:0]  col;
        logic [10:0] rows;
        logic [10:0] cols;
    } t_piece;

    // Outcome of the split of one request
    typedef struct packed {
        logic                         fail;
        t_piece [NUM_REGIONS-1:0]     piece;
    } t_split;

endpackage

// ===== rtl/core/rgsr_split.sv =====
// Combinational split of one submap request into its four quadrant pieces.
module rgsr_split import rgsr_pkg::*; (
    input  t_cfg   i_cfg,
    input  t_req   i_req,
    output t_split o_split
);

    localparam logic [10:0] DIM_MAX = 11'(MAX_DIM);

    logic [10:0] rr, cc_n;
    logic [11:0] dr, dc, ur, uc;
    logic [11:0] fit_r, fit_c;
    logic [11:0] bsum_r, bsum_c, bw_r, bw_c;
    logic [10:0] br, bc;
    logic        ra, ca, rb, cb;
    logic        bad_size, bad_idx, empty, ovf, back;
    logic        wrap_r, wrap_c;
    logic [10:0] top_rows, left_cols, bot_rows, right_cols;
    logic        kr, kc, row_use, col_use;
    logic [9:0]  p_row, p_col;
    logic [10:0] p_rows, p_cols;

    always_comb begin
        rr   = i_cfg.buf_rows;
        cc_n = i_cfg.buf_cols;

        // Configuration and request range checks
        bad_size = (rr == 11'd0) || (cc_n == 11'd0) || (rr > DIM_MAX) || (cc_n > DIM_MAX);
        bad_idx  = ({1'b0, i_req.corner_row} >= rr) || ({1'b0, i_req.corner_col} >= cc_n)
                || ({1'b0, i_cfg.origin_row} >= rr) || ({1'b0, i_cfg.origin_col} >= cc_n);
        empty    = (i_req.span_rows == 11'd0) || (i_req.span_cols == 11'd0);

        // Unwrapped corner position relative to the origin
        dr = {2'b00, i_req.corner_row} - {2'b00, i_cfg.origin_row};
        dc = {2'b00, i_req.corner_col} - {2'b00, i_cfg.origin_col};
        ur = dr[11] ? dr + {1'b0, rr}   : dr;
        uc = dc[11] ? dc + {1'b0, cc_n} : dc;

        // Submap must fit inside the buffer
        fit_r = {1'b0, ur[10:0]} + {1'b0, i_req.span_rows};
        fit_c = {1'b0, uc[10:0]} + {1'b0, i_req.span_cols};
        ovf   = (fit_r > {1'b0, rr}) || (fit_c > {1'b0, cc_n});

        // Wrapped bottom-right corner
        bsum_r = {2'b00, i_req.corner_row} + {1'b0, i_req.span_rows} - 12'd1;
        bsum_c = {2'b00, i_req.corner_col} + {1'b0, i_req.span_cols} - 12'd1;
        bw_r   = (bsum_r >= {1'b0, rr})   ? bsum_r - {1'b0, rr}   : bsum_r;
        bw_c   = (bsum_c >= {1'b0, cc_n}) ? bsum_c - {1'b0, cc_n} : bsum_c;
        br     = bw_r[10:0];
        bc     = bw_c[10:0];

        // Quadrant of each corner: set means before the origin
        ra = i_req.corner_row < i_cfg.origin_row;
        ca = i_req.corner_col < i_cfg.origin_col;
        rb = br < {1'b0, i_cfg.origin_row};
        cb = bc < {1'b0, i_cfg.origin_col};
        back = (ra && !rb) || (ca && !cb);

        wrap_r = rb && !ra;
        wrap_c = cb && !ca;
        top_rows   = wrap_r ? rr - {1'b0, i_req.corner_row}   : i_req.span_rows;
        left_cols  = wrap_c ? cc_n - {1'b0, i_req.corner_col} : i_req.span_cols;
        bot_rows   = i_req.span_rows - top_rows;
        right_cols = i_req.span_cols - left_cols;

        o_split.fail = bad_size || bad_idx || empty || ovf || back;

        // Each region takes its row extent and column extent independently
        for (int k = 0; k < NUM_REGIONS; k++) begin
            kr = k[1];
            kc = k[0];
            row_use = 1'b0;
            col_use = 1'b0;
            p_row   = '0;
            p_col   = '0;
            p_rows  = '0;
            p_cols  = '0;
            if (kr == ra) begin
                row_use = 1'b1;
                p_row   = i_req.corner_row;
                p_rows  = top_rows;
            end else if (kr && wrap_r) begin
                row_use = 1'b1;
                p_rows  = bot_rows;
            end
            if (kc == ca) begin
                col_use = 1'b1;
                p_col   = i_req.corner_col;
                p_cols  = left_cols;
            end else if (kc && wrap_c) begin
                col_use = 1'b1;
                p_cols  = right_cols;
            end
            if (row_use && col_use) begin
                o_split.piece[k] = '{row: p_row, col: p_col, rows: p_rows, cols: p_cols};
            end else begin
                o_split.piece[k] = '0;
            end
        end
    end

endmodule

// ===== rtl/core/ring_grid_submap_region_split.sv =====
// Top level: request register, split logic, result bank and result sequencer.
// A request passes through the request register and then the result bank before its first
// result shows; it waits in the request register while the bank holds the previous results.
// Results stream one per cycle from the result bank (a failed request gives a single result),
// and the next request is accepted and split meanwhile.
// The receiver cannot stall: busy rises only while a split request waits for the bank.
// Synchronous active-low reset clears valids and restores configuration defaults.
module ring_grid_submap_region_split import rgsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel
    output logic        o_res_strobe,
    output t_res        o_res,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_req   r_req;
    logic   r_req_valid;
    t_split w_split;
    t_split r_bank;
    logic   r_bank_valid;
    logic [1:0] r_idx;

    logic   w_last, w_bank_free, w_move, w_accept;
    t_piece w_piece;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buf_rows   <= RST_BUF_ROWS;
            r_cfg.buf_cols   <= RST_BUF_COLS;
            r_cfg.origin_row <= RST_ORIGIN_ROW;
            r_cfg.origin_col <= RST_ORIGIN_COL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUF_ROWS:   r_cfg.buf_rows   <= i_cfg_data;
                CFG_BUF_COLS:   r_cfg.buf_cols   <= i_cfg_data;
                CFG_ORIGIN_ROW: r_cfg.origin_row <= i_cfg_data[9:0];
                CFG_ORIGIN_COL: r_cfg.origin_col <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Handshake: the bank frees when it shows its last result this cycle
    assign w_last      = r_bank.fail || (r_idx == 2'(NUM_REGIONS - 1));
    assign w_bank_free = !r_bank_valid || w_last;
    assign w_move      = r_req_valid && w_bank_free;
    assign busy        = r_req_valid && !w_bank_free;
    assign w_accept    = start && !busy;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (w_accept) begin
            r_req_valid <= 1'b1;
        end else if (w_move) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    rgsr_split u_split (
        .i_cfg   (r_cfg),
        .i_req   (r_req),
        .o_split (w_split)
    );

    // Result bank and region counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_valid <= 1'b0;
            r_idx        <= 2'd0;
        end else if (w_move) begin
            r_bank_valid <= 1'b1;
            r_idx        <= 2'd0;
        end else if (r_bank_valid) begin
            if (w_last) begin
                r_bank_valid <= 1'b0;
                r_idx        <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_bank <= w_split;
        end
    end

    // Result transaction
    assign w_piece      = r_bank.piece[r_idx];
    assign o_res_strobe = r_bank_valid;

    always_comb begin
        if (r_bank.fail) begin
            o_res = '0;
            o_res.final_piece = 1'b1;
        end else begin
            o_res.region_id   = r_idx;
            o_res.piece_row   = w_piece.row;
            o_res.piece_col   = w_piece.col;
            o_res.piece_rows  = w_piece.rows;
            o_res.piece_cols  = w_piece.cols;
            o_res.success     = 1'b1;
            o_res.final_piece = w_last;
        end
    end

endmodule

// ===== dv/ring_grid_submap_region_split_tb.sv =====
// Self-checking testbench for the ring grid submap region split block.
`timescale 1ns / 1ps

module ring_grid_submap_region_split_tb;
    import rgsr_pkg::*;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        o_res_strobe;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_BUF_ROWS;
    logic [10:0] i_cfg_data  = '0;

    ring_grid_submap_region_split dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Requests waiting to be driven, and pieces the split should produce
    t_req request_q[$];
    t_res expected_pieces[$];
    t_cfg grid_cfg;

    logic req_fire = 1'b0;
    int   idle_pct = 0;
    int   error_count = 0;
    int   req_count = 0;
    int   piece_count = 0;
    int   reject_count = 0;
    int   cfg_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Fold a value in [-size, 2*size) back into [0, size)
    function automatic int wrap_once(int v, int size);
        if (v < 0) return v + size;
        if (v >= size) return v - size;
        return v;
    endfunction

    // Work out the region pieces for one request under the current config
    function automatic void predict_split(t_req rq);
        int     nrows, ncols, orow, ocol, cr, cc, sr, sc;
        int     ur, uc, br, bc, top_rows, left_cols, a;
        int     ra, ca, rb, cb;
        bit     rejected;
        t_piece pcs [NUM_REGIONS];
        t_res   r;
        nrows = grid_cfg.buf_rows;
        ncols = grid_cfg.buf_cols;
        orow  = grid_cfg.origin_row;
        ocol  = grid_cfg.origin_col;
        cr = rq.corner_row;
        cc = rq.corner_col;
        sr = rq.span_rows;
        sc = rq.span_cols;
        r  = '0;

        rejected = nrows < 1 || ncols < 1 || nrows > MAX_DIM || ncols > MAX_DIM
                || cr >= nrows || cc >= ncols || orow >= nrows || ocol >= ncols
                || sr == 0 || sc == 0;
        if (!rejected) begin
            ur = wrap_once(cr - orow, nrows);
            uc = wrap_once(cc - ocol, ncols);
            rejected = (ur + sr > nrows) || (uc + sc > ncols);
        end
        if (!rejected) begin
            br = wrap_once(cr + sr - 1, nrows);
            bc = wrap_once(cc + sc - 1, ncols);
            ra = (cr < orow);
            ca = (cc < ocol);
            rb = (br < orow);
            cb = (bc < ocol);
            rejected = (ra > rb) || (ca > cb);
        end
        if (rejected) begin
            r.final_piece = 1'b1;
            expected_pieces.push_back(r);
            return;
        end

        for (int k = 0; k < NUM_REGIONS; k++) pcs[k] = '0;
        top_rows  = (rb > ra) ? nrows - cr : sr;
        left_cols = (cb > ca) ? ncols - cc : sc;
        a = ra * 2 + ca;

        pcs[a].row  = 10'(cr);
        pcs[a].col  = 10'(cc);
        pcs[a].rows = 11'(top_rows);
        pcs[a].cols = 11'(left_cols);
        // piece that wraps past the right edge
        if (cb > ca) begin
            pcs[a+1].row  = 10'(cr);
            pcs[a+1].rows = 11'(top_rows);
            pcs[a+1].cols = 11'(sc - left_cols);
        end
        // piece that wraps past the bottom edge
        if (rb > ra) begin
            pcs[a+2].col  = 10'(cc);
            pcs[a+2].rows = 11'(sr - top_rows);
            pcs[a+2].cols = 11'(left_cols);
        end
        // piece that wraps past both edges
        if (rb > ra && cb > ca) begin
            pcs[3].rows = 11'(sr - top_rows);
            pcs[3].cols = 11'(sc - left_cols);
        end

        for (int k = 0; k < NUM_REGIONS; k++) begin
            r.region_id   = 2'(k);
            r.piece_row   = pcs[k].row;
            r.piece_col   = pcs[k].col;
            r.piece_rows  = pcs[k].rows;
            r.piece_cols  = pcs[k].cols;
            r.success     = 1'b1;
            r.final_piece = (k == NUM_REGIONS - 1);
            expected_pieces.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic t_req make_req(int cr, int cc, int sr, int sc);
        t_req rq;
        rq.corner_row = 10'(cr);
        rq.corner_col = 10'(cc);
        rq.span_rows  = 11'(sr);
        rq.span_cols  = 11'(sc);
        return rq;
    endfunction

    function automatic int span_within(int room);
        case ($urandom_range(3))
            0:       return room;
            1:       return 1;
            default: return $urandom_range(1, room);
        endcase
    endfunction

    // Mostly submaps that fit, with some overflow, empty and raw noise
    function automatic t_req random_request();
        int nrows, ncols, orow, ocol, cr, cc, room_r, room_c, pick, sr, sc;
        nrows = grid_cfg.buf_rows;
        ncols = grid_cfg.buf_cols;
        orow  = grid_cfg.origin_row;
        ocol  = grid_cfg.origin_col;
        pick  = $urandom_range(99);
        if (nrows < 1 || ncols < 1 || nrows > MAX_DIM || ncols > MAX_DIM
                || orow >= nrows || ocol >= ncols || pick < 12)
            return make_req($urandom_range(1023), $urandom_range(1023),
                            $urandom_range(1024), $urandom_range(1024));
        cr = $urandom_range(nrows - 1);
        cc = $urandom_range(ncols - 1);
        room_r = nrows - wrap_once(cr - orow, nrows);
        room_c = ncols - wrap_once(cc - ocol, ncols);
        sr = span_within(room_r);
        sc = span_within(room_c);
        // broken request: one dimension overflows or is empty
        if (pick < 24) begin
            if ($urandom_range(1) && room_r < 1024) sr = room_r + 1;
            else if ($urandom_range(1) && room_c < 1024) sc = room_c + 1;
            else if ($urandom_range(1)) sr = 0;
            else sc = 0;
        end
        return make_req(cr, cc, sr, sc);
    endfunction

    // Request driver: holds a request until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (req_fire) void'(request_q.pop_front());
            if (start && !req_fire) begin
                // still waiting on busy
            end else if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= request_q[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: config shadow, predictions on accept, checks on strobe
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            grid_cfg = '{RST_BUF_ROWS, RST_BUF_COLS, RST_ORIGIN_ROW, RST_ORIGIN_COL};
        end else begin
            req_fire <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_count++;
                case (i_cfg_index)
                    CFG_BUF_ROWS:   grid_cfg.buf_rows   = i_cfg_data;
                    CFG_BUF_COLS:   grid_cfg.buf_cols   = i_cfg_data;
                    CFG_ORIGIN_ROW: grid_cfg.origin_row = i_cfg_data[9:0];
                    CFG_ORIGIN_COL: grid_cfg.origin_col = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (o_res_strobe) begin
                if (expected_pieces.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, o_res);
                end else begin
                    want = expected_pieces.pop_front();
                    check_field("region_id",   want.region_id,   o_res.region_id);
                    check_field("piece_row",   want.piece_row,   o_res.piece_row);
                    check_field("piece_col",   want.piece_col,   o_res.piece_col);
                    check_field("piece_rows",  want.piece_rows,  o_res.piece_rows);
                    check_field("piece_cols",  want.piece_cols,  o_res.piece_cols);
                    check_field("success",     want.success,     o_res.success);
                    check_field("final_piece", want.final_piece, o_res.final_piece);
                    piece_count++;
                    if (!want.success) reject_count++;
                end
            end
            if (start && !busy) begin
                predict_split(i_req);
                req_count++;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 11'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int nrows, int ncols, int orow, int ocol);
        write_reg(CFG_BUF_ROWS, nrows);
        write_reg(CFG_BUF_COLS, ncols);
        write_reg(CFG_ORIGIN_ROW, orow);
        write_reg(CFG_ORIGIN_COL, ocol);
        @(posedge i_clk);
    endtask

    // Wait until every request is taken and every piece has arrived
    task automatic wait_idle();
        while (request_q.size() != 0 || start || expected_pieces.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(int nrows, int ncols, int orow, int ocol, int n, int pct);
        set_config(nrows, ncols, orow, ocol);
        idle_pct = pct;
        repeat (n) request_q.push_back(random_request());
        wait_idle();
    endtask

    // Stimulus sequence
    initial begin
        int nrows, pct;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default geometry: extremes, empty and overflow requests
        idle_pct = 0;
        request_q.push_back(make_req(0, 0, 1024, 1024));
        request_q.push_back(make_req(1023, 1023, 1, 1));
        request_q.push_back(make_req(0, 0, 1, 1));
        request_q.push_back(make_req(1023, 0, 2, 1));
        request_q.push_back(make_req(0, 1023, 1, 2));
        request_q.push_back(make_req(0, 0, 0, 5));
        request_q.push_back(make_req(5, 5, 5, 0));
        request_q.push_back(make_req(512, 512, 512, 512));
        request_q.push_back(make_req(1023, 1023, 1024, 1024));
        repeat (40) request_q.push_back(random_request());
        wait_idle();

        // shifted origin: each quadrant, wraps, out-of-range corners
        set_config(640, 480, 600, 100);
        idle_pct = 56;
        request_q.push_back(make_req(600, 100, 40, 380));
        request_q.push_back(make_req(610, 200, 100, 50));
        request_q.push_back(make_req(10, 50, 20, 30));
        request_q.push_back(make_req(620, 450, 50, 100));
        request_q.push_back(make_req(300, 470, 20, 40));
        request_q.push_back(make_req(640, 0, 1, 1));
        request_q.push_back(make_req(0, 480, 1, 1));
        request_q.push_back(make_req(599, 99, 640, 480));
        request_q.push_back(make_req(600, 100, 640, 480));
        request_q.push_back(make_req(599, 99, 1, 1));
        repeat (50) request_q.push_back(random_request());
        wait_idle();

        // register extremes, origin out of range, bad buffer sizes
        run_phase(1024, 1024, 1023, 1023, 50, 0);
        run_phase(1, 1, 0, 0, 20, 6);
        run_phase(30, 900, 50, 899, 10, 0);
        run_phase(0, 1024, 0, 0, 8, 56);
        run_phase(2047, 17, 3, 16, 8, 6);
        run_phase(1000, 3, 999, 2, 40, 56);

        // random geometries, many of them small
        for (int p = 0; p < 6; p++) begin
            nrows = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 1024);
            case (p % 3)
                0:       pct = 0;
                1:       pct = 56;
                default: pct = 6;
            endcase
            run_phase(nrows, $urandom_range(1, 1024), $urandom_range(nrows - 1), 0, 0, pct);
            // column origin must fit the column count just written
            write_reg(CFG_ORIGIN_COL, $urandom_range(grid_cfg.buf_cols - 1));
            @(posedge i_clk);
            repeat (30) request_q.push_back(random_request());
            wait_idle();
        end

        $display("Covered %0d requests (%0d results, %0d rejections) over %0d register writes.",
                 req_count, piece_count, reject_count, cfg_count);
        $display("Geometries ranged from 1x1 to 1024x1024 with shifted origins and bad sizes.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
